// ===== rtl/sbpa_pkg.sv =====
// Shared types and constants for the scan byte stream pixel assembler.
package sbpa_pkg;

    // Pixel format codes held in the format register.
    localparam logic [2:0] FMT_GRAY1  = 3'd0;
    localparam logic [2:0] FMT_GRAY8  = 3'd1;
    localparam logic [2:0] FMT_GRAY16 = 3'd2;
    localparam logic [2:0] FMT_RGB8   = 3'd3;
    localparam logic [2:0] FMT_RGB16  = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 4'd1;

    // Widths fixed by the field definitions.
    localparam int FMT_W   = 3;
    localparam int WIDTH_W = 15;
    localparam int LBYTE_W = 18;
    localparam int POS_W   = 17;
    localparam int PART_W  = 40;

    // Line geometry and control handed from the configuration block to the core.
    typedef struct packed {
        logic [FMT_W-1:0]   fmt;
        logic               fmt_ok;
        logic [2:0]         bpp;
        logic [LBYTE_W-1:0] line_bytes;
        logic               restart;
    } t_geom;

endpackage

// ===== rtl/sbpa_cfg.sv =====
// Configuration registers and line geometry for the pixel assembler.
module sbpa_cfg #(
    parameter int MAX_LINE_PIXELS = 16384
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sbpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sbpa_pkg::t_geom                  o_geom
);

    localparam logic [16:0] MaxW = 17'(MAX_LINE_PIXELS);

    logic [sbpa_pkg::FMT_W-1:0]   r_fmt;
    logic [sbpa_pkg::WIDTH_W-1:0] r_width;
    logic [sbpa_pkg::WIDTH_W-1:0] eff_w;
    logic [sbpa_pkg::LBYTE_W-1:0] w_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= sbpa_pkg::FMT_GRAY8;
            r_width <= 15'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sbpa_pkg::CFG_PIXEL_FORMAT) begin
                r_fmt <= i_cfg_data[sbpa_pkg::FMT_W-1:0];
            end
            if (i_cfg_index == sbpa_pkg::CFG_LINE_WIDTH) begin
                r_width <= i_cfg_data;
            end
        end
    end

    // Zero width counts as one pixel; widths past the limit are clamped.
    always_comb begin
        eff_w = r_width;
        if (r_width == '0) begin
            eff_w = 15'd1;
        end else if ({2'b00, r_width} > MaxW) begin
            eff_w = MaxW[sbpa_pkg::WIDTH_W-1:0];
        end
    end

    assign w_ext = {3'b000, eff_w};

    always_comb begin
        o_geom.fmt        = r_fmt;
        o_geom.fmt_ok     = 1'b1;
        o_geom.bpp        = 3'd1;
        o_geom.line_bytes = w_ext;
        case (r_fmt)
            sbpa_pkg::FMT_GRAY1: begin
                o_geom.line_bytes = (w_ext + 18'd7) >> 3;
            end
            sbpa_pkg::FMT_GRAY8: begin
                o_geom.line_bytes = w_ext;
            end
            sbpa_pkg::FMT_GRAY16: begin
                o_geom.bpp        = 3'd2;
                o_geom.line_bytes = w_ext << 1;
            end
            sbpa_pkg::FMT_RGB8: begin
                o_geom.bpp        = 3'd3;
                o_geom.line_bytes = (w_ext << 1) + w_ext;
            end
            sbpa_pkg::FMT_RGB16: begin
                o_geom.bpp        = 3'd6;
                o_geom.line_bytes = (w_ext << 2) + (w_ext << 1);
            end
            default: begin
                o_geom.fmt_ok = 1'b0;
            end
        endcase
        o_geom.restart = i_cfg_we &&
            (i_cfg_index == sbpa_pkg::CFG_PIXEL_FORMAT ||
             i_cfg_index == sbpa_pkg::CFG_LINE_WIDTH);
    end

endmodule

// ===== rtl/sbpa_core.sv =====
// Line state, byte merge and result register of the pixel assembler.
module sbpa_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbpa_pkg::t_geom     i_geom,
    input  logic                i_in_valid,
    input  logic [7:0]          i_in_byte,
    output logic                o_advance,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [13:0]         o_pixel_x,
    output logic [15:0]         o_line_index,
    output logic [15:0]         o_red,
    output logic [15:0]         o_green,
    output logic [15:0]         o_blue,
    output logic [7:0]          o_mono_bits,
    output logic                o_line_end
);

    logic [sbpa_pkg::POS_W-1:0]  r_pos;
    logic [sbpa_pkg::POS_W-1:0]  r_quo;
    logic [2:0]                  r_rem;
    logic [15:0]                 r_line_count;
    logic [sbpa_pkg::PART_W-1:0] r_partial;
    logic [2:0]                  r_phase;

    logic [2:0]                  phase_eff;
    logic [47:0]                 merged;
    logic                        emit;
    logic                        last;
    logic [sbpa_pkg::POS_W-1:0]  pos_inc;
    logic                        out_free;
    logic                        take;
    logic [15:0]                 n_red;
    logic [15:0]                 n_green;
    logic [15:0]                 n_blue;
    logic [7:0]                  n_mono;

    assign phase_eff = (r_phase >= i_geom.bpp) ? 3'd0 : r_phase;

    always_comb begin
        merged = {8'h00, r_partial};
        case (phase_eff)
            3'd0:    merged[7:0]   = i_in_byte;
            3'd1:    merged[15:8]  = i_in_byte;
            3'd2:    merged[23:16] = i_in_byte;
            3'd3:    merged[31:24] = i_in_byte;
            3'd4:    merged[39:32] = i_in_byte;
            3'd5:    merged[47:40] = i_in_byte;
            default: merged        = {8'h00, r_partial};
        endcase
    end

    assign emit    = ({1'b0, phase_eff} + 4'd1) == {1'b0, i_geom.bpp};
    assign pos_inc = r_pos + 17'd1;
    assign last    = ({1'b0, r_pos} + 18'd1) >= i_geom.line_bytes;

    // An item that yields no result moves on even while the result register waits.
    assign out_free  = !o_valid || !i_stall;
    assign o_advance = i_in_valid && (!i_geom.fmt_ok || !emit || out_free);
    assign take      = o_advance && i_geom.fmt_ok;

    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        n_mono  = '0;
        case (i_geom.fmt)
            sbpa_pkg::FMT_GRAY1: begin
                n_mono = i_in_byte;
            end
            sbpa_pkg::FMT_GRAY8: begin
                n_red   = {8'h00, i_in_byte};
                n_green = {8'h00, i_in_byte};
                n_blue  = {8'h00, i_in_byte};
            end
            sbpa_pkg::FMT_GRAY16: begin
                n_red   = merged[15:0];
                n_green = merged[15:0];
                n_blue  = merged[15:0];
            end
            sbpa_pkg::FMT_RGB8: begin
                n_red   = {8'h00, merged[7:0]};
                n_green = {8'h00, merged[15:8]};
                n_blue  = {8'h00, merged[23:16]};
            end
            default: begin
                n_red   = merged[15:0];
                n_green = merged[31:16];
                n_blue  = merged[47:32];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_quo        <= '0;
            r_rem        <= '0;
            r_line_count <= '0;
            r_partial    <= '0;
            r_phase      <= '0;
        end else if (i_geom.restart) begin
            r_pos     <= '0;
            r_quo     <= '0;
            r_rem     <= '0;
            r_partial <= '0;
            r_phase   <= '0;
        end else if (take) begin
            if (last) begin
                r_pos     <= '0;
                r_quo     <= '0;
                r_rem     <= '0;
                r_partial <= '0;
                r_phase   <= '0;
                if (r_line_count != 16'hFFFF) begin
                    r_line_count <= r_line_count + 16'd1;
                end
            end else begin
                r_pos     <= pos_inc;
                r_partial <= merged[sbpa_pkg::PART_W-1:0];
                r_phase   <= emit ? 3'd0 : phase_eff + 3'd1;
                // Quotient and remainder of the byte position by the pixel size.
                if (pos_inc == '0) begin
                    r_quo <= '0;
                    r_rem <= '0;
                end else if ((r_rem + 3'd1) == i_geom.bpp) begin
                    r_quo <= r_quo + 17'd1;
                    r_rem <= '0;
                end else begin
                    r_rem <= r_rem + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_free) begin
            o_valid <= take && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && take && emit) begin
            o_pixel_x    <= r_quo[13:0];
            o_line_index <= r_line_count;
            o_red        <= n_red;
            o_green      <= n_green;
            o_blue       <= n_blue;
            o_mono_bits  <= n_mono;
            o_line_end   <= last;
        end
    end

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && last && !i_geom.restart) |=> (r_pos == '0 && r_phase == 3'd0))
        else $error("line state not cleared after the last byte of a line");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= 3'd5)
        else $error("channel phase out of range");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line_count == 16'hFFFF) |=> (r_line_count == 16'hFFFF))
        else $error("line counter wrapped");

    a_single_byte_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_geom.bpp == 3'd1) |=> o_valid)
        else $error("single byte pixel did not produce a result beat");

endmodule

// ===== rtl/scan_byte_stream_pixel_assembler.sv =====
// Top level of the scan byte stream pixel assembler.
// The block turns a raw scanner byte stream into pixels at one byte per clock.
// Each input beat carries one byte; it is held in an input register, then
// merged into the pixel under assembly, and a completed pixel (or, in 1-bit
// gray mode, every byte) is written to the output register as one result beat
// with its pixel index, line number and a line-end flag. A new byte is taken
// every cycle as long as the output side keeps up; the output register is the
// only place a stall from downstream holds the stream. Bytes that complete no
// pixel still move on while a result waits. 8- and 16-bit gray values are
// copied to all three channels; 8-bit modes return values in the low byte.
// Writing either configuration register restarts the current line but keeps
// the line count, which stops at its maximum. Unused format codes drop bytes
// silently. Writes to the configuration port are only allowed while no beat is
// in flight.
module scan_byte_stream_pixel_assembler #(
    parameter int MAX_LINE_PIXELS = 16384
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sbpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [7:0]                       i_data_byte,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [13:0]                      o_pixel_x,
    output logic [15:0]                      o_line_index,
    output logic [15:0]                      o_red,
    output logic [15:0]                      o_green,
    output logic [15:0]                      o_blue,
    output logic [7:0]                       o_mono_bits,
    output logic                             o_line_end
);

    sbpa_pkg::t_geom geom;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       advance;

    sbpa_cfg #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    // The input register is free when empty or when its byte moves on this cycle.
    assign o_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    sbpa_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_in_valid   (r_in_valid),
        .i_in_byte    (r_in_byte),
        .o_advance    (advance),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_pixel_x    (o_pixel_x),
        .o_line_index (o_line_index),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_mono_bits  (o_mono_bits),
        .o_line_end   (o_line_end)
    );

endmodule

// ===== verif/sbpa_pixel_checker.sv =====
// Checker for the scan byte stream pixel assembler: predicts each result beat and compares it.
module sbpa_pixel_checker #(
    parameter int MAX_LINE_PIXELS = 16384
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sbpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [13:0]                      i_pixel_x,
    input  logic [15:0]                      i_line_index,
    input  logic [15:0]                      i_red,
    input  logic [15:0]                      i_green,
    input  logic [15:0]                      i_blue,
    input  logic [7:0]                       i_mono_bits,
    input  logic                             i_line_end,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int PRINT_CAP = 100;
    localparam int POS_BITS  = sbpa_pkg::POS_W;

    typedef struct packed {
        logic [13:0] pixel_x;
        logic [15:0] line_index;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [7:0]  mono;
        logic        line_end;
    } t_pixel_beat;

    t_pixel_beat                          expected_pixels[$];
    logic [sbpa_pkg::FMT_W-1:0]           cur_fmt = sbpa_pkg::FMT_GRAY8;
    logic [sbpa_pkg::WIDTH_W-1:0]         cur_width = 1;
    logic [sbpa_pkg::POS_W-1:0]           byte_pos = '0;
    logic [15:0]                          line_cnt = '0;
    // Six bytes: an RGB16 pixel is complete only with its last byte in place.
    logic [47:0]                          pixel_bytes = '0;
    logic [2:0]                           byte_slot = '0;
    int                                   fail_count = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        fail_count++;
        // Printing stops after a while so a broken block cannot flood the log.
        if (fail_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
    endtask

    task automatic restart_line();
        byte_pos    = '0;
        pixel_bytes = '0;
        byte_slot   = '0;
    endtask

    task automatic assemble_byte(input logic [7:0] b);
        int unsigned w;
        int unsigned bpp;
        int unsigned line_bytes;
        int unsigned pos;
        logic        emit;
        logic        last;
        t_pixel_beat beat;
        w = (cur_width == 0) ? 1 : cur_width;
        if (w > MAX_LINE_PIXELS) w = MAX_LINE_PIXELS;
        case (cur_fmt)
            sbpa_pkg::FMT_GRAY1:  begin bpp = 1; line_bytes = (w + 7) / 8; end
            sbpa_pkg::FMT_GRAY8:  begin bpp = 1; line_bytes = w; end
            sbpa_pkg::FMT_GRAY16: begin bpp = 2; line_bytes = w * 2; end
            sbpa_pkg::FMT_RGB8:   begin bpp = 3; line_bytes = w * 3; end
            sbpa_pkg::FMT_RGB16:  begin bpp = 6; line_bytes = w * 6; end
            default:              return;
        endcase
        pos = byte_pos;
        if (byte_slot >= bpp) byte_slot = '0;
        pixel_bytes[8*byte_slot +: 8] = b;
        emit = (byte_slot + 1 == bpp);
        byte_slot = emit ? 3'd0 : byte_slot + 3'd1;
        last = (pos + 1 >= line_bytes);
        if (emit) begin
            beat = '0;
            beat.pixel_x    = 14'(pos / bpp);
            beat.line_index = line_cnt;
            beat.line_end   = last;
            case (cur_fmt)
                sbpa_pkg::FMT_GRAY1: beat.mono = b;
                sbpa_pkg::FMT_GRAY8: begin
                    beat.red = {8'h00, b}; beat.green = {8'h00, b}; beat.blue = {8'h00, b};
                end
                sbpa_pkg::FMT_GRAY16: begin
                    beat.red   = pixel_bytes[15:0];
                    beat.green = pixel_bytes[15:0];
                    beat.blue  = pixel_bytes[15:0];
                end
                sbpa_pkg::FMT_RGB8: begin
                    beat.red   = {8'h00, pixel_bytes[7:0]};
                    beat.green = {8'h00, pixel_bytes[15:8]};
                    beat.blue  = {8'h00, pixel_bytes[23:16]};
                end
                default: begin
                    beat.red   = pixel_bytes[15:0];
                    beat.green = pixel_bytes[31:16];
                    beat.blue  = pixel_bytes[47:32];
                end
            endcase
            expected_pixels.push_back(beat);
        end
        if (last) begin
            restart_line();
            if (line_cnt != 16'hFFFF) line_cnt++;
        end else begin
            byte_pos = POS_BITS'(pos + 1);
        end
    endtask

    task automatic check_beat();
        t_pixel_beat want;
        if (expected_pixels.size() == 0) begin
            flag_mismatch("result with nothing expected", 32'(i_pixel_x), 32'd0);
            return;
        end
        want = expected_pixels.pop_front();
        if (i_pixel_x !== want.pixel_x)
            flag_mismatch("pixel_x", 32'(i_pixel_x), 32'(want.pixel_x));
        if (i_line_index !== want.line_index)
            flag_mismatch("line_index", 32'(i_line_index), 32'(want.line_index));
        if (i_red !== want.red) flag_mismatch("red", 32'(i_red), 32'(want.red));
        if (i_green !== want.green) flag_mismatch("green", 32'(i_green), 32'(want.green));
        if (i_blue !== want.blue) flag_mismatch("blue", 32'(i_blue), 32'(want.blue));
        if (i_mono_bits !== want.mono)
            flag_mismatch("mono_bits", 32'(i_mono_bits), 32'(want.mono));
        if (i_line_end !== want.line_end)
            flag_mismatch("line_end", 32'(i_line_end), 32'(want.line_end));
    endtask

    // Results are compared before the byte of the same edge is predicted, so a
    // stray result can never be matched against a byte that was just taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_fmt   = sbpa_pkg::FMT_GRAY8;
            cur_width = 1;
            line_cnt  = '0;
            restart_line();
            expected_pixels.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_beat();
            if (i_cfg_we) begin
                if (i_cfg_index == sbpa_pkg::CFG_PIXEL_FORMAT) begin
                    cur_fmt = i_cfg_data[sbpa_pkg::FMT_W-1:0];
                    restart_line();
                end else if (i_cfg_index == sbpa_pkg::CFG_LINE_WIDTH) begin
                    cur_width = i_cfg_data[sbpa_pkg::WIDTH_W-1:0];
                    restart_line();
                end
            end
            if (i_in_valid && !i_in_stall) assemble_byte(i_data_byte);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_pixels.size();
    end

endmodule

// ===== verif/scan_byte_stream_pixel_assembler_test.sv =====
// Testbench top for the scan byte stream pixel assembler: stimulus, stalls and verdict.
module scan_byte_stream_pixel_assembler_test;

    localparam int MAX_PIXELS = 16384;
    localparam int IDX_W      = sbpa_pkg::CFG_IDX_W;
    localparam int DATA_W     = sbpa_pkg::CFG_DATA_W;
    // Format codes and register indexes the block has no use for.
    localparam logic [2:0] FMT_UNUSED_LO = 3'd5;
    localparam logic [2:0] FMT_UNUSED_HI = 3'd7;
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE_LO = 4'd2;
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE_HI = 4'd15;
    // A byte passes the input register before it reaches the output register, so
    // the extra settle cycles cover any byte in flight that completes no pixel.
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 630;
    // Receiver hold-off length. The watchdog limit sits well above it, since
    // a hold-off is the longest stretch of a correct run with no beat moving.
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [DATA_W-1:0]     cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            in_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [13:0]           pixel_x;
    logic [15:0]           line_index;
    logic [15:0]           red;
    logic [15:0]           green;
    logic [15:0]           blue;
    logic [7:0]            mono_bits;
    logic                  line_end;
    int                    fail_count;
    int                    pending;

    // Bytes waiting to be offered to the block, filled by the stimulus code.
    logic [7:0]            byte_stream[$];
    // Handshake between the stimulus and the receiver for the long hold-off.
    bit                    hold_req = 1'b0;
    bit                    hold_on = 1'b0;
    int                    quiet_cycles = 0;

    scan_byte_stream_pixel_assembler #(
        .MAX_LINE_PIXELS(MAX_PIXELS)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_data_byte  (in_byte),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_pixel_x    (pixel_x),
        .o_line_index (line_index),
        .o_red        (red),
        .o_green      (green),
        .o_blue       (blue),
        .o_mono_bits  (mono_bits),
        .o_line_end   (line_end)
    );

    sbpa_pixel_checker #(
        .MAX_LINE_PIXELS(MAX_PIXELS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_data_byte  (in_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_pixel_x    (pixel_x),
        .i_line_index (line_index),
        .i_red        (red),
        .i_green      (green),
        .i_blue       (blue),
        .i_mono_bits  (mono_bits),
        .i_line_end   (line_end),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The watchdog counts cycles in which no beat moves on either channel and
    // no register is written. A hung block ends the run here.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // The receiver stalls on its own pattern: segments of random length, each
    // with a mode of its own. Mode zero never stalls and gives long stretches
    // of full throughput. A hold-off request from the stimulus is served at
    // the start of the next segment and raises the stall for HOLD_CYCLES.
    initial begin
        int seg_len;
        int mode;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_on  = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on = 1'b0;
            end
            mode = $urandom_range(0, 4);
            seg_len = (mode == 4) ? $urandom_range(1, 8) : $urandom_range(8, 64);
            repeat (seg_len) begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    3: out_stall <= ~out_stall;
                    default: out_stall <= 1'b1;
                endcase
                @(posedge clk);
            end
        end
    end

    // Offers every queued byte. The sender works in bursts of random length
    // with random gaps between them; with fast set it never pauses. Valid stays
    // high across a burst, so the next byte simply replaces the accepted one.
    task automatic feed_stream(input bit fast);
        int burst_left;
        int gap;
        burst_left = 0;
        while (byte_stream.size() != 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 32);
                gap = 0;
                if (!fast && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 7);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            in_valid <= 1'b1;
            in_byte  <= byte_stream.pop_front();
            do @(posedge clk); while (in_stall);
            burst_left--;
        end
    endtask

    // Stops offering and waits until every predicted result has come out,
    // then lets bytes that complete no pixel clear the pipeline. The first
    // edge lets the checker count the byte accepted last.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Sets both registers while the block is idle, in random order. The format
    // word sometimes carries junk above the three format bits, which the block
    // has to ignore.
    task automatic configure(input logic [2:0] fmt,
                             input logic [sbpa_pkg::WIDTH_W-1:0] width);
        logic [DATA_W-1:0] fmt_word;
        settle();
        fmt_word = '0;
        if ($urandom_range(0, 3) == 0) fmt_word = DATA_W'($urandom);
        fmt_word[2:0] = fmt;
        if ($urandom_range(0, 1) == 0) begin
            write_reg(sbpa_pkg::CFG_PIXEL_FORMAT, fmt_word);
            write_reg(sbpa_pkg::CFG_LINE_WIDTH, width);
        end else begin
            write_reg(sbpa_pkg::CFG_LINE_WIDTH, width);
            write_reg(sbpa_pkg::CFG_PIXEL_FORMAT, fmt_word);
        end
    endtask

    task automatic queue_random(input int count);
        repeat (count) byte_stream.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int          random_fed;
        int          phase_len;
        int          eff_w;
        int          line_bytes;
        int          sel;
        logic [2:0]  fmt;
        logic [14:0] width;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The reset configuration (8-bit gray, one pixel per
        // line) is used first without any write, with the byte extremes.
        byte_stream = '{8'h00, 8'hFF, 8'h5A};
        feed_stream(1'b0);

        // 16-bit gray, little-endian samples, two pixels per line.
        configure(sbpa_pkg::FMT_GRAY16, 15'd2);
        byte_stream = '{8'h34, 8'h12, 8'hFF, 8'hFF};
        feed_stream(1'b0);

        // 8-bit interleaved RGB.
        configure(sbpa_pkg::FMT_RGB8, 15'd1);
        byte_stream = '{8'h00, 8'h80, 8'hFF};
        feed_stream(1'b0);

        // 16-bit RGB: two bytes of a pixel, then a format write that must
        // throw the partial pixel away and restart the line.
        configure(sbpa_pkg::FMT_RGB16, 15'd1);
        byte_stream = '{8'hAA, 8'hBB};
        feed_stream(1'b0);
        settle();
        write_reg(sbpa_pkg::CFG_PIXEL_FORMAT, DATA_W'(sbpa_pkg::FMT_RGB16));
        byte_stream = '{8'h01, 8'h02, 8'h03, 8'h04, 8'hFF, 8'hFF};
        feed_stream(1'b0);

        // 1-bit gray, nine pixels need two bytes per line.
        configure(sbpa_pkg::FMT_GRAY1, 15'd9);
        byte_stream = '{8'h80, 8'h01};
        feed_stream(1'b0);

        // Unused format codes drop their bytes and leave the state alone.
        configure(FMT_UNUSED_LO, 15'd3);
        byte_stream = '{8'h33};
        feed_stream(1'b0);
        settle();
        write_reg(sbpa_pkg::CFG_PIXEL_FORMAT, DATA_W'(FMT_UNUSED_HI));
        byte_stream = '{8'hCC};
        feed_stream(1'b0);

        // A line width of zero acts as one pixel. Writes to indexes past the
        // register list must change nothing, not even the line position.
        configure(sbpa_pkg::FMT_GRAY8, 15'd0);
        write_reg(CFG_IDX_SPARE_LO, DATA_W'($urandom));
        write_reg(CFG_IDX_SPARE_HI, DATA_W'($urandom));
        byte_stream = '{8'h77, 8'h00};
        feed_stream(1'b0);

        // Long receiver hold-off while the sender keeps offering: the output
        // register fills, then the input side has to stall.
        configure(sbpa_pkg::FMT_RGB8, 15'd5);
        queue_random(120);
        hold_req = 1'b1;
        wait (hold_on);
        feed_stream(1'b1);

        // Random part. Most phases are whole lines of a valid format with
        // random content, often followed by a partial line that the next
        // register write cuts off. A few phases use an unused format code;
        // their bytes are noise and do not count toward the item total.
        random_fed = 0;
        while (random_fed < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel == 19) fmt = 3'($urandom_range(FMT_UNUSED_LO, FMT_UNUSED_HI));
            else fmt = 3'(sel % 5);
            sel = $urandom_range(0, 9);
            if (sel < 6) width = 15'($urandom_range(1, 12));
            else if (sel < 9) width = 15'($urandom_range(13, 80));
            else width = 15'd0;
            configure(fmt, width);
            if ($urandom_range(0, 4) == 0)
                write_reg(IDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                          DATA_W'($urandom));

            eff_w = (width == 0) ? 1 : width;
            case (fmt)
                sbpa_pkg::FMT_GRAY1:  line_bytes = (eff_w + 7) / 8;
                sbpa_pkg::FMT_GRAY8:  line_bytes = eff_w;
                sbpa_pkg::FMT_GRAY16: line_bytes = eff_w * 2;
                sbpa_pkg::FMT_RGB8:   line_bytes = eff_w * 3;
                sbpa_pkg::FMT_RGB16:  line_bytes = eff_w * 6;
                default:              line_bytes = 0;
            endcase
            if (line_bytes == 0) begin
                phase_len = $urandom_range(1, 8);
            end else begin
                phase_len = line_bytes * $urandom_range(1, 4);
                if ($urandom_range(0, 1) == 0) phase_len += $urandom_range(0, line_bytes - 1);
                if (phase_len > 240) phase_len = 240;
                if (phase_len > RANDOM_ITEMS - random_fed) phase_len = RANDOM_ITEMS - random_fed;
                random_fed += phase_len;
            end
            queue_random(phase_len);
            // Now and then a phase runs with no sender gaps at all.
            feed_stream($urandom_range(0, 5) == 0);
        end

        // The sender also pauses here until every expected result is out.
        settle();

        // Widest line: the first pixels of a line at the largest width.
        configure(sbpa_pkg::FMT_GRAY8, 15'd16384);
        queue_random(40);
        feed_stream(1'b0);

        // A width far above the maximum is clamped; the start of such a 1-bit line.
        configure(sbpa_pkg::FMT_GRAY1, 15'h7FFF);
        queue_random(20);
        feed_stream(1'b0);

        // The line count carries on across register writes into another format.
        configure(sbpa_pkg::FMT_RGB16, 15'd3);
        queue_random(18);
        feed_stream(1'b0);

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
